// File: hw/rtl/ies_pkg.sv
// ----------------------------------------------------------------------------
// ies_pkg
// Shared types and constants of the interval erase splitter.
// ----------------------------------------------------------------------------
package ies_pkg;

    localparam int MAX_RANGES_DEF = 16;
    localparam int FRAME_BITS_DEF = 40;

    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_ADD   = 2'd1;
    localparam logic [1:0] MODE_POINT = 2'd2;
    localparam logic [1:0] MODE_NOTE  = 2'd3;

    localparam logic [2:0] KIND_ACK       = 3'd0;
    localparam logic [2:0] KIND_UNCHANGED = 3'd1;
    localparam logic [2:0] KIND_REMOVED   = 3'd2;
    localparam logic [2:0] KIND_PIECE     = 3'd3;
    localparam logic [2:0] KIND_FULL      = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHK,
        S_RD,
        S_PROC,
        S_ADD_END,
        S_PT_END,
        S_NOTE_MID,
        S_TAIL,
        S_LAST,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic       start;
        logic       start_note;
        logic       clr;
        logic       rd;
        logic       adv;
        logic       wr_new;
        logic       wr_ent;
        logic       merge;
        logic       rewind;
        logic       note_step;
        logic       pend_tail;
        logic       swap;
        logic       out_load;
        logic       out_pend;
        logic       out_last;
        logic [2:0] out_kind;
    } cmd_t;

    typedef struct packed {
        logic e_le_s;
        logic idx_done;
        logic last_entry;
        logic f_lt_s;
        logic b_gt_e;
        logic n_full;
        logic placed;
        logic covered;
        logic overlap;
        logic full_cov;
        logic piece;
        logic pend_valid;
        logic from_lt_end;
        logic out_free;
    } status_t;

endpackage

// File: hw/rtl/interval_erase_splitter_unit.sv
// ----------------------------------------------------------------------------
// interval_erase_splitter_unit
// Erased-range table with point and note queries.
// ----------------------------------------------------------------------------
// One word is taken at a time. An add, point or note walks the live range
// table with one registered memory read per entry; a note that is split
// walks it a second time to emit the pieces, and any output stall holds
// the walk. An add rebuilds the table in a second bank, so a range that
// does not fit leaves the old table untouched. The table needs no clearing
// after reset.
module interval_erase_splitter_unit #(
    parameter int MAX_RANGES = ies_pkg::MAX_RANGES_DEF,
    parameter int FRAME_BITS = ies_pkg::FRAME_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            mode,
    input  logic [FRAME_BITS-1:0] item_start,
    input  logic [FRAME_BITS-1:0] item_extent,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [2:0]            kind,
    output logic [FRAME_BITS-1:0] piece_start,
    output logic [FRAME_BITS-1:0] piece_length,
    output logic                  last
);

    ies_pkg::cmd_t    cmd;
    ies_pkg::status_t status;

    ies_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .mode     (mode),
        .status   (status),
        .cmd      (cmd)
    );

    ies_dp #(
        .MAX_RANGES (MAX_RANGES),
        .FRAME_BITS (FRAME_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .item_start   (item_start),
        .item_extent  (item_extent),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .piece_start  (piece_start),
        .piece_length (piece_length),
        .last         (last)
    );

endmodule

// File: hw/rtl/ies_dp.sv
// ----------------------------------------------------------------------------
// ies_dp
// Datapath: two banks of range table, working registers, compares and the
// output word register.
// ----------------------------------------------------------------------------
module ies_dp #(
    parameter int MAX_RANGES = ies_pkg::MAX_RANGES_DEF,
    parameter int FRAME_BITS = ies_pkg::FRAME_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ies_pkg::cmd_t         cmd,
    output ies_pkg::status_t      status,
    input  logic [FRAME_BITS-1:0] item_start,
    input  logic [FRAME_BITS-1:0] item_extent,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [2:0]            kind,
    output logic [FRAME_BITS-1:0] piece_start,
    output logic [FRAME_BITS-1:0] piece_length,
    output logic                  last
);

    localparam int IW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CW = $clog2(MAX_RANGES + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_RANGES);

    logic [FRAME_BITS-1:0] b0_mem [MAX_RANGES];
    logic [FRAME_BITS-1:0] f0_mem [MAX_RANGES];
    logic [FRAME_BITS-1:0] b1_mem [MAX_RANGES];
    logic [FRAME_BITS-1:0] f1_mem [MAX_RANGES];

    logic [FRAME_BITS-1:0] b0_rd_reg, f0_rd_reg, b1_rd_reg, f1_rd_reg;
    logic [FRAME_BITS-1:0] s_reg, e_reg, from_reg, pend_s_reg, pend_e_reg;
    logic [CW-1:0]         idx_reg, n_reg, count_reg;
    logic                  bank_reg, placed_reg, cov_reg, ovl_reg, full_reg;
    logic                  pend_valid_reg;
    logic                  out_valid_reg, last_reg;
    logic [2:0]            kind_reg;
    logic [FRAME_BITS-1:0] pstart_reg, plen_reg;

    logic [FRAME_BITS:0]   sum;
    logic [FRAME_BITS-1:0] note_end, rd_b, rd_f, wr_b, wr_f;
    logic                  wr_en, take, cov_hit, ovl_hit, full_hit;
    logic [CW-1:0]         idx_inc, n_next;

    assign sum      = {1'b0, item_start} + {1'b0, item_extent};
    assign note_end = sum[FRAME_BITS] ? '1 : sum[FRAME_BITS-1:0];
    assign rd_b     = bank_reg ? b1_rd_reg : b0_rd_reg;
    assign rd_f     = bank_reg ? f1_rd_reg : f0_rd_reg;
    assign wr_en    = cmd.wr_new | cmd.wr_ent;
    assign wr_b     = cmd.wr_new ? s_reg : rd_b;
    assign wr_f     = cmd.wr_new ? e_reg : rd_f;
    assign idx_inc  = idx_reg + 1'b1;
    assign n_next   = wr_en ? n_reg + 1'b1 : n_reg;

    assign cov_hit  = (s_reg >= rd_b) && (s_reg < rd_f);
    assign ovl_hit  = (rd_f > s_reg) && (rd_b < e_reg);
    assign full_hit = (rd_b <= s_reg) && (rd_f >= e_reg);
    assign take     = (rd_f > from_reg) && (rd_b < e_reg);

    assign status.e_le_s      = e_reg <= s_reg;
    assign status.idx_done    = idx_reg == count_reg;
    assign status.last_entry  = idx_inc == count_reg;
    assign status.f_lt_s      = rd_f < s_reg;
    assign status.b_gt_e      = rd_b > e_reg;
    assign status.n_full      = n_reg == MAX_CNT;
    assign status.placed      = placed_reg;
    assign status.covered     = cov_reg;
    assign status.overlap     = ovl_reg;
    assign status.full_cov    = full_reg;
    assign status.piece       = take && (rd_b > from_reg);
    assign status.pend_valid  = pend_valid_reg;
    assign status.from_lt_end = from_reg < e_reg;
    assign status.out_free    = !out_valid_reg || !out_stall;

    // Table banks: reads come from the live bank, an insert rebuilds the
    // other bank and the banks swap when it completes.
    always_ff @(posedge clk)
    begin
        if (wr_en && bank_reg)
        begin
            b0_mem[n_reg[IW-1:0]] <= wr_b;
            f0_mem[n_reg[IW-1:0]] <= wr_f;
        end
        if (wr_en && !bank_reg)
        begin
            b1_mem[n_reg[IW-1:0]] <= wr_b;
            f1_mem[n_reg[IW-1:0]] <= wr_f;
        end
        if (cmd.rd)
        begin
            b0_rd_reg <= b0_mem[idx_reg[IW-1:0]];
            f0_rd_reg <= f0_mem[idx_reg[IW-1:0]];
            b1_rd_reg <= b1_mem[idx_reg[IW-1:0]];
            f1_rd_reg <= f1_mem[idx_reg[IW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            s_reg    <= item_start;
            from_reg <= item_start;
            e_reg    <= cmd.start_note ? note_end : item_extent;
        end
        else
        begin
            if (cmd.merge)
            begin
                if (rd_b < s_reg)
                    s_reg <= rd_b;
                if (rd_f > e_reg)
                    e_reg <= rd_f;
            end
            if (cmd.rewind)
                from_reg <= s_reg;
            else if (cmd.note_step && take)
                from_reg <= rd_f;
        end
        if (cmd.note_step && take && (rd_b > from_reg))
        begin
            pend_s_reg <= from_reg;
            pend_e_reg <= rd_b;
        end
        else if (cmd.pend_tail)
        begin
            pend_s_reg <= from_reg;
            pend_e_reg <= e_reg;
        end
        if (cmd.out_load)
        begin
            kind_reg <= cmd.out_kind;
            last_reg <= cmd.out_last;
            if (cmd.out_pend)
            begin
                pstart_reg <= pend_s_reg;
                plen_reg   <= pend_e_reg - pend_s_reg;
            end
            else
            begin
                pstart_reg <= '0;
                plen_reg   <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            n_reg          <= '0;
            count_reg      <= '0;
            bank_reg       <= 1'b0;
            placed_reg     <= 1'b0;
            cov_reg        <= 1'b0;
            ovl_reg        <= 1'b0;
            full_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.start || cmd.rewind)
            begin
                idx_reg        <= '0;
                pend_valid_reg <= 1'b0;
            end
            else
            begin
                if (cmd.adv)
                    idx_reg <= idx_inc;
                if (cmd.note_step && take && (rd_b > from_reg))
                    pend_valid_reg <= 1'b1;
                else if (cmd.pend_tail)
                    pend_valid_reg <= 1'b1;
            end
            if (cmd.start)
            begin
                n_reg      <= '0;
                placed_reg <= 1'b0;
                cov_reg    <= 1'b0;
                ovl_reg    <= 1'b0;
                full_reg   <= 1'b0;
            end
            else
            begin
                n_reg <= n_next;
                if (cmd.wr_new)
                    placed_reg <= 1'b1;
                if (cmd.adv && !cmd.note_step)
                begin
                    cov_reg  <= cov_reg | cov_hit;
                    ovl_reg  <= ovl_reg | ovl_hit;
                    full_reg <= full_reg | full_hit;
                end
            end
            if (cmd.clr)
                count_reg <= '0;
            else if (cmd.swap)
            begin
                count_reg <= n_next;
                bank_reg  <= !bank_reg;
            end
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign piece_start  = pstart_reg;
    assign piece_length = plen_reg;
    assign last         = last_reg;

endmodule

// File: hw/rtl/ies_ctrl.sv
// ----------------------------------------------------------------------------
// ies_ctrl
// Controller: sequences the table walk for each input word.
// ----------------------------------------------------------------------------
module ies_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [1:0]       mode,
    input  ies_pkg::status_t status,
    output ies_pkg::cmd_t    cmd
);

    ies_pkg::state_t state_reg, state_next;
    logic [1:0]      mode_reg, mode_next;
    logic            pass2_reg, pass2_next;
    logic [2:0]      kind_reg, kind_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ies_pkg::S_IDLE;
            mode_reg  <= ies_pkg::MODE_CLEAR;
            pass2_reg <= 1'b0;
            kind_reg  <= ies_pkg::KIND_ACK;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            pass2_reg <= pass2_next;
            kind_reg  <= kind_next;
        end
    end

    assign in_stall = state_reg != ies_pkg::S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        pass2_next = pass2_reg;
        kind_next  = kind_reg;
        cmd        = '0;
        case (state_reg)
            ies_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start      = 1'b1;
                    cmd.start_note = mode == ies_pkg::MODE_NOTE;
                    mode_next      = mode;
                    pass2_next     = 1'b0;
                    if (mode == ies_pkg::MODE_CLEAR)
                    begin
                        cmd.clr    = 1'b1;
                        kind_next  = ies_pkg::KIND_ACK;
                        state_next = ies_pkg::S_EMIT;
                    end
                    else
                        state_next = ies_pkg::S_CHK;
                end
            end
            ies_pkg::S_CHK:
            begin
                if (mode_reg == ies_pkg::MODE_ADD)
                begin
                    if (status.e_le_s)
                    begin
                        kind_next  = ies_pkg::KIND_ACK;
                        state_next = ies_pkg::S_EMIT;
                    end
                    else if (status.idx_done)
                        state_next = ies_pkg::S_ADD_END;
                    else
                        state_next = ies_pkg::S_RD;
                end
                else if (mode_reg == ies_pkg::MODE_NOTE && !status.e_le_s)
                    state_next = status.idx_done ? ies_pkg::S_NOTE_MID : ies_pkg::S_RD;
                else
                begin
                    // A point event, or a note that collapses to a point.
                    mode_next  = ies_pkg::MODE_POINT;
                    state_next = status.idx_done ? ies_pkg::S_PT_END : ies_pkg::S_RD;
                end
            end
            ies_pkg::S_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = ies_pkg::S_PROC;
            end
            ies_pkg::S_PROC:
            begin
                if (mode_reg == ies_pkg::MODE_ADD)
                begin
                    if (!status.f_lt_s && !status.b_gt_e)
                    begin
                        cmd.merge  = 1'b1;
                        cmd.adv    = 1'b1;
                        state_next = status.last_entry ? ies_pkg::S_ADD_END
                                                       : ies_pkg::S_RD;
                    end
                    else if (status.n_full)
                    begin
                        kind_next  = ies_pkg::KIND_FULL;
                        state_next = ies_pkg::S_EMIT;
                    end
                    else if (status.b_gt_e && !status.placed)
                        cmd.wr_new = 1'b1;
                    else
                    begin
                        cmd.wr_ent = 1'b1;
                        cmd.adv    = 1'b1;
                        state_next = status.last_entry ? ies_pkg::S_ADD_END
                                                       : ies_pkg::S_RD;
                    end
                end
                else if (mode_reg == ies_pkg::MODE_POINT)
                begin
                    cmd.adv    = 1'b1;
                    state_next = status.last_entry ? ies_pkg::S_PT_END : ies_pkg::S_RD;
                end
                else if (!pass2_reg)
                begin
                    cmd.adv    = 1'b1;
                    state_next = status.last_entry ? ies_pkg::S_NOTE_MID : ies_pkg::S_RD;
                end
                else if (status.out_free)
                begin
                    // A new stretch pushes the held one out; it is not the last.
                    if (status.piece && status.pend_valid)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.out_pend = 1'b1;
                        cmd.out_kind = ies_pkg::KIND_PIECE;
                    end
                    cmd.note_step = 1'b1;
                    cmd.adv       = 1'b1;
                    state_next    = status.last_entry ? ies_pkg::S_TAIL : ies_pkg::S_RD;
                end
            end
            ies_pkg::S_ADD_END:
            begin
                if (!status.placed && status.n_full)
                    kind_next = ies_pkg::KIND_FULL;
                else
                begin
                    cmd.wr_new = !status.placed;
                    cmd.swap   = 1'b1;
                    kind_next  = ies_pkg::KIND_ACK;
                end
                state_next = ies_pkg::S_EMIT;
            end
            ies_pkg::S_PT_END:
            begin
                kind_next  = status.covered ? ies_pkg::KIND_REMOVED
                                            : ies_pkg::KIND_UNCHANGED;
                state_next = ies_pkg::S_EMIT;
            end
            ies_pkg::S_NOTE_MID:
            begin
                if (!status.overlap)
                begin
                    kind_next  = ies_pkg::KIND_UNCHANGED;
                    state_next = ies_pkg::S_EMIT;
                end
                else if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = ies_pkg::KIND_REMOVED;
                    cmd.out_last = status.full_cov;
                    if (status.full_cov)
                        state_next = ies_pkg::S_IDLE;
                    else
                    begin
                        cmd.rewind = 1'b1;
                        pass2_next = 1'b1;
                        state_next = ies_pkg::S_RD;
                    end
                end
            end
            ies_pkg::S_TAIL:
            begin
                if (!status.from_lt_end)
                    state_next = ies_pkg::S_LAST;
                else if (!status.pend_valid)
                begin
                    cmd.pend_tail = 1'b1;
                    state_next    = ies_pkg::S_LAST;
                end
                else if (status.out_free)
                begin
                    cmd.out_load  = 1'b1;
                    cmd.out_pend  = 1'b1;
                    cmd.out_kind  = ies_pkg::KIND_PIECE;
                    cmd.pend_tail = 1'b1;
                    state_next    = ies_pkg::S_LAST;
                end
            end
            ies_pkg::S_LAST:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_pend = 1'b1;
                    cmd.out_kind = ies_pkg::KIND_PIECE;
                    cmd.out_last = 1'b1;
                    state_next   = ies_pkg::S_IDLE;
                end
            end
            ies_pkg::S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = kind_reg;
                    cmd.out_last = 1'b1;
                    state_next   = ies_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ies_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// File: bench/interval_erase_splitter_checker.sv
// ----------------------------------------------------------------------------
// interval_erase_splitter_checker
// Watches both channels of the erase splitter, predicts every output word
// from its own copy of the erased-range table, and counts mismatches.
// ----------------------------------------------------------------------------
module interval_erase_splitter_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  logic [1:0]                         mode,
    input  logic [ies_pkg::FRAME_BITS_DEF-1:0] item_start,
    input  logic [ies_pkg::FRAME_BITS_DEF-1:0] item_extent,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  logic [2:0]                         kind,
    input  logic [ies_pkg::FRAME_BITS_DEF-1:0] piece_start,
    input  logic [ies_pkg::FRAME_BITS_DEF-1:0] piece_length,
    input  logic                               last,
    output int                                 fails,
    output int                                 pending
);

    localparam int FB = ies_pkg::FRAME_BITS_DEF;
    localparam int NR = ies_pkg::MAX_RANGES_DEF;
    localparam logic [FB-1:0] FRAME_MAX = {FB{1'b1}};

    typedef struct packed {
        logic [2:0]    kind;
        logic [FB-1:0] pstart;
        logic [FB-1:0] plen;
        logic          lst;
    } out_word_t;

    logic [FB-1:0] erased_lo [NR];
    logic [FB-1:0] erased_hi [NR];
    int            live_ranges;
    out_word_t     expected_words [$];

    initial
    begin
        fails       = 0;
        pending     = 0;
        live_ranges = 0;
    end

    function automatic void expect_word(logic [2:0] k, logic [FB-1:0] s,
                                        logic [FB-1:0] len, logic l);
        out_word_t w;
        w.kind   = k;
        w.pstart = s;
        w.plen   = len;
        w.lst    = l;
        expected_words = {expected_words, w};
    endfunction

    function automatic bit frame_erased(logic [FB-1:0] f);
        for (int i = 0; i < live_ranges; i++)
            if (f >= erased_lo[i] && f < erased_hi[i])
                return 1'b1;
        return 1'b0;
    endfunction

    // Rebuilds the table with the new range merged in; a result that would
    // not fit leaves the table as it was.
    function automatic bit insert_range(logic [FB-1:0] s, logic [FB-1:0] e);
        logic [FB-1:0] nlo [NR+1];
        logic [FB-1:0] nhi [NR+1];
        int            n;
        bit            placed;
        n = 0;
        placed = 1'b0;
        if (e <= s)
            return 1'b1;
        for (int i = 0; i < live_ranges; i++)
        begin
            if (erased_hi[i] < s)
            begin
                nlo[n] = erased_lo[i]; nhi[n] = erased_hi[i]; n++;
            end
            else if (erased_lo[i] > e)
            begin
                if (!placed)
                begin
                    nlo[n] = s; nhi[n] = e; n++; placed = 1'b1;
                end
                nlo[n] = erased_lo[i]; nhi[n] = erased_hi[i]; n++;
            end
            else
            begin
                if (erased_lo[i] < s) s = erased_lo[i];
                if (erased_hi[i] > e) e = erased_hi[i];
            end
        end
        if (!placed)
        begin
            nlo[n] = s; nhi[n] = e; n++;
        end
        if (n > NR)
            return 1'b0;
        for (int i = 0; i < n; i++)
        begin
            erased_lo[i] = nlo[i];
            erased_hi[i] = nhi[i];
        end
        live_ranges = n;
        return 1'b1;
    endfunction

    function automatic void predict_word(logic [1:0] m, logic [FB-1:0] s,
                                         logic [FB-1:0] x);
        logic [FB:0]   sum;
        logic [FB-1:0] note_end;
        logic [FB-1:0] from;
        logic [FB-1:0] pc_lo [NR+1];
        logic [FB-1:0] pc_hi [NR+1];
        int            np;
        np = 0;
        case (m)
            ies_pkg::MODE_CLEAR:
            begin
                live_ranges = 0;
                expect_word(ies_pkg::KIND_ACK, '0, '0, 1'b1);
            end
            ies_pkg::MODE_ADD:
                expect_word(insert_range(s, x) ? ies_pkg::KIND_ACK : ies_pkg::KIND_FULL,
                            '0, '0, 1'b1);
            ies_pkg::MODE_POINT:
                expect_word(frame_erased(s) ? ies_pkg::KIND_REMOVED
                                            : ies_pkg::KIND_UNCHANGED,
                            '0, '0, 1'b1);
            default:
            begin
                sum = {1'b0, s} + {1'b0, x};
                note_end = (sum > {1'b0, FRAME_MAX}) ? FRAME_MAX : sum[FB-1:0];
                if (note_end <= s)
                begin
                    expect_word(frame_erased(s) ? ies_pkg::KIND_REMOVED
                                                : ies_pkg::KIND_UNCHANGED,
                                '0, '0, 1'b1);
                    return;
                end
                from = s;
                for (int i = 0; i < live_ranges; i++)
                begin
                    if (erased_hi[i] <= from) continue;
                    if (erased_lo[i] >= note_end) break;
                    if (erased_lo[i] > from)
                    begin
                        pc_lo[np] = from; pc_hi[np] = erased_lo[i]; np++;
                    end
                    from = erased_hi[i];
                    if (from >= note_end) break;
                end
                if (from < note_end)
                begin
                    pc_lo[np] = from; pc_hi[np] = note_end; np++;
                end
                if (np == 1 && pc_lo[0] == s && pc_hi[0] == note_end)
                begin
                    expect_word(ies_pkg::KIND_UNCHANGED, '0, '0, 1'b1);
                    return;
                end
                expect_word(ies_pkg::KIND_REMOVED, '0, '0, np == 0);
                for (int i = 0; i < np; i++)
                    expect_word(ies_pkg::KIND_PIECE, pc_lo[i], pc_hi[i] - pc_lo[i],
                                i + 1 == np);
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_word_t w;
        if (!rst_n)
        begin
            live_ranges = 0;
            expected_words.delete();
        end
        else
        begin
            // Output words always belong to earlier input words, so check first.
            if (out_valid && !out_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    $display("%0t: unexpected word kind=%0d start=%0d len=%0d last=%0b",
                             $time, kind, piece_start, piece_length, last);
                    fails++;
                end
                else
                begin
                    w = expected_words.pop_front();
                    if (kind !== w.kind)
                    begin
                        $display("%0t: kind expected %0d actual %0d", $time, w.kind, kind);
                        fails++;
                    end
                    if (piece_start !== w.pstart)
                    begin
                        $display("%0t: piece_start expected %0d actual %0d",
                                 $time, w.pstart, piece_start);
                        fails++;
                    end
                    if (piece_length !== w.plen)
                    begin
                        $display("%0t: piece_length expected %0d actual %0d",
                                 $time, w.plen, piece_length);
                        fails++;
                    end
                    if (last !== w.lst)
                    begin
                        $display("%0t: last expected %0b actual %0b", $time, w.lst, last);
                        fails++;
                    end
                end
            end
            if (in_valid && !in_stall)
                predict_word(mode, item_start, item_extent);
        end
        pending = expected_words.size();
    end

endmodule

// File: bench/interval_erase_splitter_unit_tb.sv
// ----------------------------------------------------------------------------
// interval_erase_splitter_unit_tb
// Drives directed and random clear, range, point and note words into the erase
// splitter with random idling on both sides; the checker judges the output.
// ----------------------------------------------------------------------------
module interval_erase_splitter_unit_tb;

    localparam int FB        = ies_pkg::FRAME_BITS_DEF;
    localparam int STALL_MAX = 3000;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_stall;
    logic [1:0]    mode = ies_pkg::MODE_CLEAR;
    logic [FB-1:0] item_start = '0;
    logic [FB-1:0] item_extent = '0;
    logic          out_valid;
    logic          out_stall = 1'b0;
    logic [2:0]    kind;
    logic [FB-1:0] piece_start;
    logic [FB-1:0] piece_length;
    logic          last;
    int            fails;
    int            pending;
    bit            calm = 1'b0;
    int            quiet_cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    interval_erase_splitter_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .mode(mode),
        .item_start(item_start), .item_extent(item_extent),
        .out_valid(out_valid), .out_stall(out_stall), .kind(kind),
        .piece_start(piece_start), .piece_length(piece_length), .last(last)
    );

    interval_erase_splitter_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .mode(mode),
        .item_start(item_start), .item_extent(item_extent),
        .out_valid(out_valid), .out_stall(out_stall), .kind(kind),
        .piece_start(piece_start), .piece_length(piece_length), .last(last),
        .fails(fails), .pending(pending)
    );

    always @(negedge clk)
        out_stall <= calm ? 1'b0 : ($urandom_range(99) < 13);

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_MAX)
        begin
            $display("FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Presents one word from a falling edge and holds it until accepted.
    task automatic send_word(logic [1:0] m, logic [FB-1:0] s, logic [FB-1:0] x);
        while (!calm && $urandom_range(99) < 13)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        mode        <= m;
        item_start  <= s;
        item_extent <= x;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    function automatic logic [FB-1:0] any_frame();
        return FB'({$urandom, $urandom});
    endfunction

    logic [FB-1:0] base;
    logic [FB-1:0] a;
    logic [FB-1:0] b;
    int            pick;

    initial
    begin
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty adds, merging of touching ranges, edges of a range.
        send_word(ies_pkg::MODE_NOTE, 40'd5, 40'd10);
        send_word(ies_pkg::MODE_ADD, 40'd50, 40'd50);
        send_word(ies_pkg::MODE_ADD, 40'd60, 40'd55);
        send_word(ies_pkg::MODE_ADD, 40'd10, 40'd20);
        send_word(ies_pkg::MODE_ADD, 40'd20, 40'd30);
        send_word(ies_pkg::MODE_POINT, 40'd9, 40'd0);
        send_word(ies_pkg::MODE_POINT, 40'd10, 40'd0);
        send_word(ies_pkg::MODE_POINT, 40'd29, 40'd0);
        send_word(ies_pkg::MODE_POINT, 40'd30, 40'd0);
        send_word(ies_pkg::MODE_NOTE, 40'd12, 40'd5);
        send_word(ies_pkg::MODE_NOTE, 40'd5, 40'd40);
        send_word(ies_pkg::MODE_NOTE, 40'd15, 40'd0);
        send_word(ies_pkg::MODE_NOTE, {FB{1'b1}} - 40'd5, {FB{1'b1}});
        send_word(ies_pkg::MODE_NOTE, {FB{1'b1}}, {FB{1'b1}});
        send_word(ies_pkg::MODE_ADD, {FB{1'b1}} - 40'd3, {FB{1'b1}});
        send_word(ies_pkg::MODE_POINT, {FB{1'b1}} - 40'd1, 40'd0);
        send_word(ies_pkg::MODE_CLEAR, {FB{1'b1}}, {FB{1'b1}});

        // Fill the table, overflow it, then split a note into the most stretches.
        calm = 1'b1;
        for (int i = 0; i < ies_pkg::MAX_RANGES_DEF; i++)
            send_word(ies_pkg::MODE_ADD, FB'(i * 10 + 1), FB'(i * 10 + 6));
        calm = 1'b0;
        send_word(ies_pkg::MODE_ADD, 40'd300, 40'd305);
        send_word(ies_pkg::MODE_NOTE, 40'd0, 40'd400);
        send_word(ies_pkg::MODE_ADD, 40'd6, 40'd11);
        send_word(ies_pkg::MODE_NOTE, 40'd0, 40'd400);
        send_word(ies_pkg::MODE_CLEAR, 40'd0, 40'd0);

        base = any_frame() >> 2;
        for (int n = 0; n < 292; n++)
        begin
            calm = (n >= 120 && n < 170);
            if ($urandom_range(99) < 4)
                base = any_frame() >> 1;
            pick = $urandom_range(99);
            if ($urandom_range(99) < 15)
            begin
                a = any_frame();
                b = any_frame();
            end
            else
            begin
                a = base + $urandom_range(600);
                b = (pick < 40) ? a + $urandom_range(40) - 4 : $urandom_range(200);
            end
            if (pick < 4)
                send_word(ies_pkg::MODE_CLEAR, a, b);
            else if (pick < 40)
                send_word(ies_pkg::MODE_ADD, a, b);
            else if (pick < 62)
                send_word(ies_pkg::MODE_POINT, a, b);
            else
                send_word(ies_pkg::MODE_NOTE, a, b);
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (fails == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
